[rtl/core/sha256_pkg.sv]
package sha256_pkg;

  localparam int unsigned LENGTH_COUNTER_BITS_DEFAULT = 64;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LENGTH_LIMIT = 56;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned QUEUE_DEPTH = 4;

  // what the front hands to the back
  typedef enum logic [1:0] {
    OP_BLOCK  = 2'd0,  // full data block, compress
    OP_FINAL  = 2'd1,  // pad, length, compress, emit digest
    OP_FINAL2 = 2'd2   // pad spills into a second block
  } op_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        byte_valid;
    logic        is_last;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } back_state_t;

  typedef logic [31:0] word_t;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INITIAL_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

[rtl/core/sha256_if.sv]
interface sha256_in_if;
  logic                  valid;
  logic                  ready;
  logic [7:0]            data_byte;
  logic                  byte_valid;
  logic                  is_last;
  modport source (output valid, data_byte, byte_valid, is_last, input ready);
  modport sink (input valid, data_byte, byte_valid, is_last, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

[rtl/core/sha256_ram.sv]
module sha256_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/sha256_front.sv]
// front: writes bytes into one of two block buffers, counts the message,
// and queues a command per full block or per message end
module sha256_front #(
  parameter int unsigned LENGTH_COUNTER_BITS = sha256_pkg::LENGTH_COUNTER_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        is_last,
  // byte buffer write port
  output logic        buf_we,
  output logic [6:0]  buf_waddr,
  output logic [7:0]  buf_wdata,
  // command queue push
  output logic        cmd_push,
  input  logic        cmd_full,
  output sha256_pkg::op_t cmd_op,
  output logic        cmd_bank,
  output logic [5:0]  cmd_fill,
  output logic [63:0] cmd_bits,
  // bank handback from the back end
  input  logic [1:0]  bank_busy
);
  logic [5:0]  fill;
  logic        bank;
  logic [63:0] count;
  logic [6:0]  fill_inc;
  logic [63:0] count_inc;
  logic [63:0] bits_full;
  logic        accept;
  logic        full_blk;

  assign fill_inc  = {1'b0, fill} + 7'd1;
  assign count_inc = count + 64'(byte_valid);
  assign bits_full = count_inc << 3;
  assign full_blk  = byte_valid && fill_inc[6];

  // stall while our bank still waits in the back, or no room to queue
  assign in_ready = !bank_busy[bank] && !cmd_full;
  assign accept   = in_valid && in_ready;

  assign buf_we    = accept && byte_valid;
  assign buf_waddr = {bank, fill};
  assign buf_wdata = data_byte;

  always_comb begin
    cmd_push = accept && (full_blk || is_last);
    cmd_bank = bank;
    cmd_fill = full_blk ? 6'd0 : (byte_valid ? fill_inc[5:0] : fill);
    if (full_blk)
      cmd_op = sha256_pkg::OP_BLOCK;
    else if (cmd_fill >= 6'(sha256_pkg::LENGTH_LIMIT))
      cmd_op = sha256_pkg::OP_FINAL2;
    else
      cmd_op = sha256_pkg::OP_FINAL;
    if (LENGTH_COUNTER_BITS >= 64)
      cmd_bits = bits_full;
    else
      cmd_bits = bits_full & ((64'd1 << LENGTH_COUNTER_BITS) - 64'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      bank  <= 1'b0;
      count <= '0;
    end else if (accept) begin
      if (is_last) begin
        // message closed, a full block here gets its pad block in the back
        fill  <= '0;
        bank  <= ~bank;
        count <= '0;
      end else if (full_blk) begin
        fill  <= '0;
        bank  <= ~bank;
        count <= count_inc;
      end else begin
        fill  <= byte_valid ? fill_inc[5:0] : fill;
        count <= count_inc;
      end
    end
  end
endmodule

[rtl/core/sha256_back.sv]
// back: one sha-256 round per cycle over the bank named by the command
module sha256_back (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_pop,
  input  sha256_pkg::op_t cmd_op,
  input  logic        cmd_bank,
  input  logic [5:0]  cmd_fill,
  input  logic [63:0] cmd_bits,
  input  logic        cmd_tail,
  output logic [6:0]  buf_raddr,
  input  logic [7:0]  buf_rdata,
  output logic [1:0]  bank_busy,
  output logic        out_valid,
  input  logic        out_ready,
  output sha256_pkg::out_beat_t out_beat
);
  sha256_pkg::back_state_t state, state_next;
  sha256_pkg::word_t h [8];
  sha256_pkg::word_t v [8];
  sha256_pkg::word_t w [16];
  logic [6:0]  cnt;        // load: byte index 0..64, round: 0..63
  logic        pass2;      // second block of a spilled pad
  logic [5:0]  ld_idx;
  logic [7:0]  ld_byte;
  logic [2:0]  oidx;
  logic        own_bank;
  sha256_pkg::word_t wt, s0, s1, t1, t2;
  logic [5:0]  rnd;

  assign bank_busy = {state != sha256_pkg::ST_IDLE && cmd_bank,
                      state != sha256_pkg::ST_IDLE && !cmd_bank};
  assign own_bank = cmd_bank;

  assign buf_raddr = {own_bank, cnt[5:0]};
  assign ld_idx = cnt[5:0] - 6'd1;

  // padding byte for load index ld_idx
  always_comb begin
    ld_byte = buf_rdata;
    if (cmd_op == sha256_pkg::OP_BLOCK) begin
      // full block that closed the message: pad block starts with the marker
      if (pass2)
        ld_byte = (ld_idx == 6'd0) ? sha256_pkg::PAD_BYTE : 8'h00;
    end else if (pass2) begin
      ld_byte = 8'h00;
    end else if (ld_idx == cmd_fill) begin
      ld_byte = sha256_pkg::PAD_BYTE;
    end else if (ld_idx > cmd_fill) begin
      ld_byte = 8'h00;
    end
    if ((pass2 || cmd_op == sha256_pkg::OP_FINAL) &&
        ld_idx >= 6'(sha256_pkg::LENGTH_LIMIT))
      ld_byte = cmd_bits[8*(7 - 32'(ld_idx[2:0])) +: 8];
  end

  assign rnd = cnt[5:0];
  always_comb begin
    s0 = sha256_pkg::rotr(w[1], 7) ^ sha256_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = sha256_pkg::rotr(w[14], 17) ^ sha256_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
    wt = (rnd < 6'd16) ? w[0] : (s1 + w[9] + s0 + w[0]);
    t1 = v[7] + (sha256_pkg::rotr(v[4], 6) ^ sha256_pkg::rotr(v[4], 11) ^
                 sha256_pkg::rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[rnd] + wt;
    t2 = (sha256_pkg::rotr(v[0], 2) ^ sha256_pkg::rotr(v[0], 13) ^
          sha256_pkg::rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  assign out_valid = state == sha256_pkg::ST_EMIT;
  assign out_beat.digest_word = h[oidx];
  assign out_beat.word_index  = oidx;
  assign out_beat.last_word   = oidx == 3'd7;

  always_comb begin
    state_next = state;
    cmd_pop = 1'b0;
    unique case (state)
      sha256_pkg::ST_IDLE: if (cmd_valid) state_next = sha256_pkg::ST_LOAD;
      sha256_pkg::ST_LOAD: if (cnt == 7'd64) state_next = sha256_pkg::ST_ROUND;
      sha256_pkg::ST_ROUND: if (cnt == 7'd63) state_next = sha256_pkg::ST_ADD;
      sha256_pkg::ST_ADD: begin
        if (cmd_op == sha256_pkg::OP_FINAL2 && !pass2)
          state_next = sha256_pkg::ST_LOAD;
        else if (cmd_op == sha256_pkg::OP_BLOCK && !cmd_tail) begin
          state_next = sha256_pkg::ST_IDLE;
          cmd_pop = 1'b1;
        end else if (cmd_op == sha256_pkg::OP_BLOCK && !pass2)
          state_next = sha256_pkg::ST_LOAD;
        else
          state_next = sha256_pkg::ST_EMIT;
      end
      sha256_pkg::ST_EMIT: if (out_ready && oidx == 3'd7) begin
        state_next = sha256_pkg::ST_IDLE;
        cmd_pop = 1'b1;
      end
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= sha256_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; pass2 <= 1'b0; oidx <= '0;
      for (int i = 0; i < 8; i++) h[i] <= sha256_pkg::INITIAL_H[i];
    end else begin
      unique case (state)
        sha256_pkg::ST_IDLE: begin
          cnt <= '0; pass2 <= 1'b0;
        end
        sha256_pkg::ST_LOAD: begin
          // read data arrives in the cycle after its address
          if (cnt != 7'd0) begin
            // a new word starts every fourth byte, push the finished one down
            if (ld_idx[1:0] == 2'd0)
              for (int i = 0; i < 15; i++) w[i] <= w[i+1];
            w[15] <= {w[15][23:0], ld_byte};
          end
          if (cnt == 7'd64) begin
            cnt <= '0;
            for (int i = 0; i < 8; i++) v[i] <= h[i];
          end else cnt <= cnt + 7'd1;
        end
        sha256_pkg::ST_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wt;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          cnt <= (cnt == 7'd63) ? 7'd0 : cnt + 7'd1;
        end
        sha256_pkg::ST_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          if (cmd_op == sha256_pkg::OP_FINAL2) pass2 <= 1'b1;
          if (cmd_op == sha256_pkg::OP_BLOCK && cmd_tail) pass2 <= 1'b1;
          oidx <= '0;
        end
        sha256_pkg::ST_EMIT: if (out_ready) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7)
            for (int i = 0; i < 8; i++) h[i] <= sha256_pkg::INITIAL_H[i];
        end
        default: ;
      endcase
    end
  end
endmodule

[rtl/core/sha256_message_hasher_unit.sv]
// sha-256 hasher taking one message byte per beat. a front end fills one of
// two 64-byte buffers (one byte per cycle unless its bank is busy in the back
// end or the command queue is full, so bytes stream in at full speed while
// the other buffer is compressed) and queues a command per full block or
// message end. the back end loads a block byte by byte through the buffer
// read port, runs 64 rounds at one round per cycle, then adds the result
// into the hash state, and passes through idle before each command. a
// message end costs one or two such blocks, then eight digest beats H0..H7.
module sha256_message_hasher_unit #(
  parameter int unsigned LENGTH_COUNTER_BITS = sha256_pkg::LENGTH_COUNTER_BITS_DEFAULT
) (
  input logic clk,
  input logic rst,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);
  logic        buf_we;
  logic [6:0]  buf_waddr, buf_raddr;
  logic [7:0]  buf_wdata, buf_rdata;
  logic        push, pop, full, qvalid;
  sha256_pkg::op_t op_in;
  logic        bank_in;
  logic [5:0]  fill_in;
  logic [63:0] bits_in;
  logic [1:0]  bank_busy;
  sha256_pkg::out_beat_t ob;

  // command queue
  typedef struct packed {
    sha256_pkg::op_t op;
    logic        bank;
    logic [5:0]  fill;
    logic [63:0] bits;
    logic        tail;
  } cmd_t;
  localparam int unsigned QW = $clog2(sha256_pkg::QUEUE_DEPTH);
  cmd_t q [sha256_pkg::QUEUE_DEPTH];
  logic [QW:0] wp, rp;
  cmd_t head;
  logic full_and_last;

  assign full_and_last = op_in == sha256_pkg::OP_BLOCK && in_ch.is_last;

  sha256_front #(.LENGTH_COUNTER_BITS(LENGTH_COUNTER_BITS)) u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .data_byte(in_ch.data_byte), .byte_valid(in_ch.byte_valid),
    .is_last(in_ch.is_last),
    .buf_we, .buf_waddr, .buf_wdata,
    .cmd_push(push), .cmd_full(full), .cmd_op(op_in), .cmd_bank(bank_in),
    .cmd_fill(fill_in), .cmd_bits(bits_in), .bank_busy
  );

  sha256_ram #(.WIDTH(8), .DEPTH(2 * sha256_pkg::BLOCK_BYTES)) u_buf (
    .clk, .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
    .raddr(buf_raddr), .rdata(buf_rdata)
  );

  assign full   = (wp - rp) == (QW+1)'(sha256_pkg::QUEUE_DEPTH);
  assign qvalid = wp != rp;
  assign head   = q[rp[QW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0;
    end else begin
      if (push) begin
        // a full block that also ends the message pads a second, empty block
        q[wp[QW-1:0]] <= '{op: op_in, bank: bank_in, fill: fill_in,
                           bits: bits_in, tail: full_and_last};
        wp <= wp + 1'b1;
      end
      if (pop) rp <= rp + 1'b1;
    end
  end

  sha256_back u_back (
    .clk, .rst,
    .cmd_valid(qvalid), .cmd_pop(pop),
    .cmd_op(head.op), .cmd_bank(head.bank), .cmd_fill(head.fill),
    .cmd_bits(head.bits), .cmd_tail(head.tail),
    .buf_raddr, .buf_rdata, .bank_busy,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_beat(ob)
  );

  assign out_ch.digest_word = ob.digest_word;
  assign out_ch.word_index  = ob.word_index;
  assign out_ch.last_word   = ob.last_word;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("command queue overflow");
  a_pop_has_cmd: assert property (@(posedge clk) disable iff (rst) pop |-> qvalid)
    else $error("pop from empty queue");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.last_word) |=> !out_ch.valid)
    else $error("digest ran past last word");
endmodule

[verif/tb_sha256_message_hasher_unit.sv]
`timescale 1ns / 1ps

module tb_sha256_message_hasher_unit;

  logic clk;
  logic rst;

  sha256_in_if  in_ch ();
  sha256_out_if out_ch ();

  sha256_message_hasher_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  sha256_pkg::word_t     hash_state [8];
  logic [7:0]            msg_block [64];
  int unsigned           block_fill;
  logic [63:0]           msg_bytes;
  sha256_pkg::out_beat_t digest_q [$];
  int unsigned           fail_count = 0;
  bit                    no_idle;

  function automatic sha256_pkg::word_t ror32(sha256_pkg::word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_msg_block();
    sha256_pkg::word_t w [16];
    sha256_pkg::word_t v [8];
    sha256_pkg::word_t wt, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        wt = w[i];
      end else begin
        s0 = ror32(w[(i-15)&15], 7) ^ ror32(w[(i-15)&15], 18) ^ (w[(i-15)&15] >> 3);
        s1 = ror32(w[(i-2)&15], 17) ^ ror32(w[(i-2)&15], 19) ^ (w[(i-2)&15] >> 10);
        wt = s1 + w[(i-7)&15] + s0 + w[i&15];
        w[i&15] = wt;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[i] + wt;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic digest_restart();
    for (int i = 0; i < 8; i++) hash_state[i] = sha256_pkg::INITIAL_H[i];
    block_fill = 0;
    msg_bytes  = '0;
  endtask

  task automatic predict_digest(sha256_pkg::in_beat_t b);
    logic [63:0]           bits;
    sha256_pkg::out_beat_t o;
    if (b.byte_valid) begin
      msg_block[block_fill] = b.data;
      block_fill++;
      msg_bytes++;
      if (block_fill == 64) begin
        compress_msg_block();
        block_fill = 0;
      end
    end
    if (!b.is_last) return;
    msg_block[block_fill] = sha256_pkg::PAD_BYTE;
    for (int i = block_fill + 1; i < 64; i++) msg_block[i] = 8'h00;
    if (block_fill + 1 > sha256_pkg::LENGTH_LIMIT) begin
      compress_msg_block();
      for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    end
    bits = msg_bytes << 3;
    for (int i = 0; i < 8; i++)
      msg_block[sha256_pkg::LENGTH_LIMIT + i] = bits[63 - 8*i -: 8];
    compress_msg_block();
    for (int i = 0; i < 8; i++) begin
      o.digest_word = hash_state[i];
      o.word_index  = 3'(i);
      o.last_word   = (i == 7);
      digest_q.push_back(o);
    end
    digest_restart();
  endtask

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 37);
  endfunction

  // valid stays up after a beat until the next call drives or idles
  task automatic send_beat(logic [7:0] d, logic bv, logic last);
    sha256_pkg::in_beat_t b;
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    b.data = d; b.byte_valid = bv; b.is_last = last;
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= d;
    in_ch.byte_valid <= bv;
    in_ch.is_last    <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_digest(b);
  endtask

  task automatic send_message(int unsigned len, bit trailing_byte);
    for (int i = 0; i < len; i++) send_beat(8'($urandom), 1'b1, 1'b0);
    send_beat(8'($urandom), trailing_byte, 1'b1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // sink side: ready toggles at random, checks every accepted beat
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest beat word=%h idx=%0d last=%0b", $time,
                   out_ch.digest_word, out_ch.word_index, out_ch.last_word);
          fail_count++;
        end else begin
          sha256_pkg::out_beat_t e;
          e = digest_q.pop_front();
          if (e.digest_word !== out_ch.digest_word) begin
            $display("%0t: digest_word expected %h actual %h", $time, e.digest_word,
                     out_ch.digest_word);
            fail_count++;
          end
          if (e.word_index !== out_ch.word_index) begin
            $display("%0t: word_index expected %0d actual %0d", $time, e.word_index,
                     out_ch.word_index);
            fail_count++;
          end
          if (e.last_word !== out_ch.last_word) begin
            $display("%0t: last_word expected %0b actual %0b", $time, e.last_word,
                     out_ch.last_word);
            fail_count++;
          end
        end
      end
      out_ch.ready <= !idle_now();
    end
  end

  task automatic test_empty_and_short();
    send_beat(8'h00, 1'b0, 1'b1);          // empty message
    send_beat(8'hff, 1'b0, 1'b0);          // ignored beat
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b1);          // last beat carries a byte
    send_beat(8'haa, 1'b1, 1'b0);
    send_beat(8'h55, 1'b0, 1'b1);          // last beat without a byte
  endtask

  task automatic test_padding_edges();
    // 56 bytes buffered spills the pad into a second block
    send_message(55, 1'b1);
    // last beat fills the block, pad goes into its own block, no idling here
    no_idle = 1'b1;
    send_message(63, 1'b1);
    no_idle = 1'b0;
  endtask

  task automatic test_drain_pause();
    send_message(3, 1'b1);
    wait_drained();
    repeat (20) @(posedge clk);
    send_message(2, 1'b0);
  endtask

  task automatic test_random_messages();
    int unsigned len;
    for (int m = 0; m < 3; m++) begin
      len = $urandom_range(8);
      for (int i = 0; i < len; i++) begin
        // occasional beat with no byte, just noise
        if ($urandom_range(9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
        send_beat(8'($urandom), 1'b1, 1'b0);
      end
      send_beat(8'($urandom), 1'($urandom), 1'b1);
    end
  endtask

  initial begin
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.byte_valid = 1'b0;
    in_ch.is_last    = 1'b0;
    no_idle          = 1'b0;
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    digest_restart();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_short();
    test_padding_edges();
    test_drain_pause();
    test_random_messages();
    wait_drained();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && digest_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
